FILE: design/ffra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit range allocator
// Table geometry, request and response structs, status codes and FSM states.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_ZERO_SIZE  = 3'd4
  } status_t;

  typedef struct packed {
    op_t   op;
    addr_t alloc_size;
    addr_t free_offset;
  } req_t;

  typedef struct packed {
    status_t status;
    addr_t   offset;
  } rsp_t;

  typedef struct packed {
    addr_t offset;
    addr_t size;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_INS_SHIFT,
    S_INS_PUT,
    S_FSCAN,
    S_DEL_SHIFT
  } state_t;

endpackage
`default_nettype wire

FILE: design/ffra_table_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_table_mem: allocation table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffra_table_mem (
  input  wire logic            clk,
  input  wire logic            we,
  input  ffra_pkg::idx_t       waddr,
  input  ffra_pkg::entry_t     wdata,
  input  ffra_pkg::idx_t       raddr,
  output ffra_pkg::entry_t     rdata
);

  ffra_pkg::entry_t mem [ffra_pkg::MAX_ENTRIES];
  ffra_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/ffra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ctrl: scan and shift sequencer of the allocator
// Walks the sorted table through the memory read port, then shifts entries
// to open or close a slot and writes the result.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  ffra_pkg::req_t       req,
  input  ffra_pkg::addr_t      pool_size,
  output logic                 rsp_valid,
  output ffra_pkg::rsp_t       rsp,
  output logic                 mem_we,
  output ffra_pkg::idx_t       mem_waddr,
  output ffra_pkg::entry_t     mem_wdata,
  output ffra_pkg::idx_t       mem_raddr,
  input  ffra_pkg::entry_t     mem_rdata
);

  ffra_pkg::state_t state_r, state_nxt;
  ffra_pkg::cnt_t   count_r, count_nxt;
  ffra_pkg::cnt_t   pos_r, pos_nxt;
  ffra_pkg::cnt_t   sh_r, sh_nxt;
  ffra_pkg::addr_t  cursor_r, cursor_nxt;
  ffra_pkg::req_t   req_r, req_nxt;
  logic             rsp_valid_r, rsp_valid_nxt;
  ffra_pkg::rsp_t   rsp_r, rsp_nxt;

  ffra_pkg::addr_t  gap;
  ffra_pkg::addr_t  tail;
  logic             accept;

  assign accept = start && (state_r == ffra_pkg::S_IDLE);
  assign busy   = (state_r != ffra_pkg::S_IDLE);
  assign gap    = mem_rdata.offset - cursor_r;
  assign tail   = pool_size - cursor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffra_pkg::S_IDLE;
      count_r     <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    sh_r     <= sh_nxt;
    cursor_r <= cursor_nxt;
    req_r    <= req_nxt;
    rsp_r    <= rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    sh_nxt        = sh_r;
    cursor_nxt    = cursor_r;
    req_nxt       = req_r;
    rsp_valid_nxt = 1'b0;
    rsp_nxt       = rsp_r;
    mem_we        = 1'b0;
    mem_waddr     = sh_r[ffra_pkg::IDX_W-1:0];
    mem_wdata     = mem_rdata;
    // The scan reads one entry ahead of the one being checked.
    mem_raddr     = ffra_pkg::idx_t'(pos_r + ffra_pkg::cnt_t'(1));

    case (state_r)
      ffra_pkg::S_IDLE: begin
        mem_raddr = '0;
        if (accept) begin
          req_nxt        = req;
          pos_nxt        = '0;
          cursor_nxt     = '0;
          rsp_nxt.offset = '0;
          if (req.op == ffra_pkg::OP_FREE) begin
            state_nxt = ffra_pkg::S_FSCAN;
          end else if (req.alloc_size == '0) begin
            rsp_valid_nxt  = 1'b1;
            rsp_nxt.status = ffra_pkg::ST_ZERO_SIZE;
          end else if (count_r == ffra_pkg::cnt_t'(ffra_pkg::MAX_ENTRIES)) begin
            rsp_valid_nxt  = 1'b1;
            rsp_nxt.status = ffra_pkg::ST_TABLE_FULL;
          end else begin
            state_nxt = ffra_pkg::S_ASCAN;
          end
        end
      end

      ffra_pkg::S_ASCAN: begin
        if (pos_r == count_r) begin
          if (pool_size >= cursor_r && tail >= req_r.alloc_size) begin
            state_nxt = ffra_pkg::S_INS_PUT;
          end else begin
            rsp_valid_nxt  = 1'b1;
            rsp_nxt.status = ffra_pkg::ST_NO_SPACE;
            state_nxt      = ffra_pkg::S_IDLE;
          end
        end else if (mem_rdata.offset >= cursor_r && gap >= req_r.alloc_size) begin
          // Open a slot at pos_r: move the upper entries up by one, top first.
          sh_nxt    = count_r;
          mem_raddr = ffra_pkg::idx_t'(count_r - ffra_pkg::cnt_t'(1));
          state_nxt = ffra_pkg::S_INS_SHIFT;
        end else begin
          cursor_nxt = mem_rdata.offset + mem_rdata.size;
          pos_nxt    = pos_r + ffra_pkg::cnt_t'(1);
        end
      end

      ffra_pkg::S_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_raddr = ffra_pkg::idx_t'(sh_r - ffra_pkg::cnt_t'(2));
        sh_nxt    = sh_r - ffra_pkg::cnt_t'(1);
        if (sh_nxt == pos_r) begin
          state_nxt = ffra_pkg::S_INS_PUT;
        end
      end

      ffra_pkg::S_INS_PUT: begin
        mem_we           = 1'b1;
        mem_waddr        = pos_r[ffra_pkg::IDX_W-1:0];
        mem_wdata.offset = cursor_r;
        mem_wdata.size   = req_r.alloc_size;
        count_nxt        = count_r + ffra_pkg::cnt_t'(1);
        rsp_valid_nxt    = 1'b1;
        rsp_nxt.status   = ffra_pkg::ST_OK;
        rsp_nxt.offset   = cursor_r;
        state_nxt        = ffra_pkg::S_IDLE;
      end

      ffra_pkg::S_FSCAN: begin
        if (pos_r == count_r) begin
          rsp_valid_nxt  = 1'b1;
          rsp_nxt.status = ffra_pkg::ST_NOT_FOUND;
          state_nxt      = ffra_pkg::S_IDLE;
        end else if (mem_rdata.offset == req_r.free_offset) begin
          // The read of the entry above the match is already under way.
          sh_nxt    = pos_r;
          state_nxt = ffra_pkg::S_DEL_SHIFT;
        end else begin
          pos_nxt = pos_r + ffra_pkg::cnt_t'(1);
        end
      end

      ffra_pkg::S_DEL_SHIFT: begin
        mem_raddr = ffra_pkg::idx_t'(sh_r + ffra_pkg::cnt_t'(2));
        if (sh_r + ffra_pkg::cnt_t'(1) == count_r) begin
          count_nxt      = count_r - ffra_pkg::cnt_t'(1);
          rsp_valid_nxt  = 1'b1;
          rsp_nxt.status = ffra_pkg::ST_OK;
          state_nxt      = ffra_pkg::S_IDLE;
        end else begin
          mem_we = 1'b1;
          sh_nxt = sh_r + ffra_pkg::cnt_t'(1);
        end
      end

      default: begin
        state_nxt = ffra_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ffra_pkg::cnt_t'(ffra_pkg::MAX_ENTRIES))
    else $error("entry count above table depth");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffra_pkg::S_INS_SHIFT || state_r == ffra_pkg::S_DEL_SHIFT) && mem_we
      |-> mem_waddr != mem_raddr)
    else $error("shift reads the entry it writes");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid_r && rsp_r.status != ffra_pkg::ST_OK |-> count_r == $past(count_r))
    else $error("failed request changed the entry count");

  a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid_r && rsp_r.status == ffra_pkg::ST_OK && req_r.op == ffra_pkg::OP_ALLOC
      |-> (count_r - $past(count_r)) == ffra_pkg::cnt_t'(1))
    else $error("granted allocation did not add an entry");

  a_offset_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid_r && rsp_r.status != ffra_pkg::ST_OK |-> rsp_r.offset == '0)
    else $error("offset reported with a failing status");
`endif

endmodule
`default_nettype wire

FILE: design/first_fit_range_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_range_allocator_unit: first-fit range allocator, top level
// Keeps a sorted table of live allocations in a single-port-read RAM and
// serves allocate and free requests against a configurable pool size.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Transfer when
//   -------   --------------------------   ---------------------------------
//   request   start, busy, in_data         start high and busy low
//   result    out_valid, out_data          out_valid high (one cycle only)
//   config    cfg_valid, cfg_ready,        cfg_valid and cfg_ready high
//             cfg_data
//
// A zero-size or table-full allocate never raises busy and answers the cycle
// after the transfer. Any other request scans the table one entry per cycle
// through the RAM read port and then, where a slot must be opened or closed,
// moves one entry per cycle. The result shows in the cycle in which busy drops.
// Reset (rst_n low, synchronous) empties the table by clearing the entry
// count and sets the pool size to zero; the RAM itself is never cleared.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// The pool size register accepts a write in every cycle.
//
module first_fit_range_allocator_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  ffra_pkg::req_t       in_data,
  output logic                 out_valid,
  output ffra_pkg::rsp_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  ffra_pkg::addr_t      cfg_data
);

  // Pool size register, written through the configuration channel.
  ffra_pkg::addr_t  pool_size_r, pool_size_nxt;

  ffra_pkg::entry_t mem_wdata, mem_rdata;
  ffra_pkg::idx_t   mem_waddr, mem_raddr;
  logic             mem_we;

  assign cfg_ready     = 1'b1;
  assign pool_size_nxt = (cfg_valid && cfg_ready) ? cfg_data : pool_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r <= '0;
    end else begin
      pool_size_r <= pool_size_nxt;
    end
  end

  // The sequencer owns the entry count and all table traffic.
  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (in_data),
    .pool_size (pool_size_r),
    .rsp_valid (out_valid),
    .rsp       (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Offset and size of each live entry, sorted by offset.
  ffra_table_mem u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
